/* sv/ipw_pkg.sv */
// Shared types and constants for the wrapping integer power block.
package ipw_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = WORD_W / 2;

	localparam logic [WORD_W-1:0] WORD_ONE      = {{(WORD_W-1){1'b0}}, 1'b1};
	localparam logic [WORD_W-1:0] WORD_ALL_ONES = {WORD_W{1'b1}};

	// Partial product steps of the shared multiplier
	localparam logic [1:0] PH_LOW     = 2'd0;	// low x low
	localparam logic [1:0] PH_CROSS_A = 2'd1;	// low a x high b
	localparam logic [1:0] PH_CROSS_B = 2'd2;	// high a x low b

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECIDE = 5'b00010,
		ST_MULT   = 5'b00100,
		ST_SQUARE = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} mul_req_t;

endpackage

/* sv/ipw_mul.sv */
// Shared 64-bit wrapping multiplier built on one 32x32 multiplier over three steps.
module ipw_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ipw_pkg::mul_req_t                   req,
	output logic                                done,
	output logic [ipw_pkg::WORD_W-1:0]          prod
);

	logic [ipw_pkg::WORD_W-1:0]   a_q;
	logic [ipw_pkg::WORD_W-1:0]   b_q;
	logic [ipw_pkg::WORD_W-1:0]   acc_q;
	logic [1:0]                   phase_q;
	logic                         busy_q;
	logic                         done_q;
	logic [ipw_pkg::HALF_W-1:0]   op_x;
	logic [ipw_pkg::HALF_W-1:0]   op_y;
	logic [ipw_pkg::WORD_W-1:0]   pp;

	// Only the low 64 bits are kept, so the high x high term never matters
	always_comb begin
		op_x = a_q[ipw_pkg::HALF_W-1:0];
		op_y = b_q[ipw_pkg::HALF_W-1:0];
		unique case (phase_q)
			ipw_pkg::PH_LOW: begin
				op_x = a_q[ipw_pkg::HALF_W-1:0];
				op_y = b_q[ipw_pkg::HALF_W-1:0];
			end
			ipw_pkg::PH_CROSS_A: begin
				op_x = a_q[ipw_pkg::HALF_W-1:0];
				op_y = b_q[ipw_pkg::WORD_W-1:ipw_pkg::HALF_W];
			end
			ipw_pkg::PH_CROSS_B: begin
				op_x = a_q[ipw_pkg::WORD_W-1:ipw_pkg::HALF_W];
				op_y = b_q[ipw_pkg::HALF_W-1:0];
			end
			default: begin
				op_x = a_q[ipw_pkg::HALF_W-1:0];
				op_y = b_q[ipw_pkg::HALF_W-1:0];
			end
		endcase
		pp = op_x * op_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= ipw_pkg::PH_LOW;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				phase_q <= ipw_pkg::PH_LOW;
			end else if (busy_q) begin
				unique case (phase_q)
					ipw_pkg::PH_LOW:     phase_q <= ipw_pkg::PH_CROSS_A;
					ipw_pkg::PH_CROSS_A: phase_q <= ipw_pkg::PH_CROSS_B;
					ipw_pkg::PH_CROSS_B: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			if (phase_q == ipw_pkg::PH_LOW) begin
				acc_q <= pp;
			end else begin
				acc_q[ipw_pkg::WORD_W-1:ipw_pkg::HALF_W] <=
					acc_q[ipw_pkg::WORD_W-1:ipw_pkg::HALF_W] + pp[ipw_pkg::HALF_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* sv/integer_power_wrapping_top.sv */
// Top level of the wrapping integer power block: sequencer and operand registers.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | to block  | in_valid / in_ready  | base_value, power_exponent
//  out     | from block| out_valid / out_ready| power_result
//
// One beat is worked on at a time; in_ready is high only when the block is idle.
// Each exponent bit, LSB first, costs one decision step, a squaring (skipped
// after the top bit) and, when set, a multiply, all on the one 32x32 multiplier
// inside ipw_mul. A zero exponent goes from the decision straight to the output;
// a negative one skips the decision. Reset clears the sequencer only. The
// result is held in acc_q until out_ready; a stalled output simply keeps the
// block busy.
module integer_power_wrapping_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [63:0] base_value,
	input  logic signed [63:0] power_exponent,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] power_result
);

	ipw_pkg::state_t                state_q;
	ipw_pkg::state_t                state_d;
	ipw_pkg::mul_req_t              mul_req;
	logic                           mul_done;
	logic [ipw_pkg::WORD_W-1:0]     mul_prod;

	logic [ipw_pkg::WORD_W-1:0]     acc_q;	// running product, then the result
	logic [ipw_pkg::WORD_W-1:0]     sq_q;	// base squared once per bit
	logic [ipw_pkg::WORD_W-1:0]     rest_q;	// exponent bits still to go
	logic [ipw_pkg::WORD_W-1:0]     base_u;
	logic [ipw_pkg::WORD_W-1:0]     exp_u;
	logic [ipw_pkg::WORD_W-1:0]     special_res;

	assign base_u = $unsigned(base_value);
	assign exp_u  = $unsigned(power_exponent);

	// Negative exponent: only 1 and -1 survive, everything else truncates to 0
	always_comb begin
		if (base_u == ipw_pkg::WORD_ONE) begin
			special_res = ipw_pkg::WORD_ONE;
		end else if (base_u == ipw_pkg::WORD_ALL_ONES) begin
			special_res = exp_u[0] ? ipw_pkg::WORD_ALL_ONES : ipw_pkg::WORD_ONE;
		end else begin
			special_res = '0;
		end
	end

	// Sequencer: LSB-first square and multiply
	always_comb begin
		state_d       = state_q;
		mul_req.start = 1'b0;
		mul_req.a     = sq_q;
		mul_req.b     = sq_q;
		unique case (state_q)
			ipw_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = exp_u[ipw_pkg::WORD_W-1] ? ipw_pkg::ST_OUT : ipw_pkg::ST_DECIDE;
				end
			end
			ipw_pkg::ST_DECIDE: begin
				if (rest_q == '0) begin
					state_d = ipw_pkg::ST_OUT;
				end else if (rest_q[0]) begin
					mul_req.start = 1'b1;
					mul_req.a     = acc_q;
					state_d       = ipw_pkg::ST_MULT;
				end else begin
					mul_req.start = 1'b1;
					state_d       = ipw_pkg::ST_SQUARE;
				end
			end
			ipw_pkg::ST_MULT: begin
				if (mul_done) begin
					if (rest_q[ipw_pkg::WORD_W-1:1] == '0) begin
						// top bit done, no further square needed
						state_d = ipw_pkg::ST_OUT;
					end else begin
						mul_req.start = 1'b1;
						state_d       = ipw_pkg::ST_SQUARE;
					end
				end
			end
			ipw_pkg::ST_SQUARE: begin
				if (mul_done) begin
					state_d = ipw_pkg::ST_DECIDE;
				end
			end
			ipw_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = ipw_pkg::ST_IDLE;
				end
			end
			default: state_d = ipw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ipw_pkg::ST_IDLE && in_valid) begin
			sq_q   <= base_u;
			rest_q <= exp_u;
			acc_q  <= exp_u[ipw_pkg::WORD_W-1] ? special_res : ipw_pkg::WORD_ONE;
		end else if (state_q == ipw_pkg::ST_MULT && mul_done) begin
			acc_q <= mul_prod;
		end else if (state_q == ipw_pkg::ST_SQUARE && mul_done) begin
			sq_q   <= mul_prod;
			rest_q <= {1'b0, rest_q[ipw_pkg::WORD_W-1:1]};
		end
	end

	ipw_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign in_ready     = (state_q == ipw_pkg::ST_IDLE);
	assign out_valid    = (state_q == ipw_pkg::ST_OUT);
	assign power_result = $signed(acc_q);

endmodule

/* sv/ipw_check.sv */
// Port-level checker for the wrapping integer power block, with its bind.
module ipw_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [63:0] base_value,
	input logic signed [63:0] power_exponent,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [63:0] power_result
);

	// A held result must not move
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(power_result))
		else $error("result changed while stalled");

	// One item in flight: no new beat taken once one is accepted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while result pending");

	// Zero exponent gives 1 once the decision state has run
	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && power_exponent == 64'sd0
		|-> ##2 (out_valid && power_result == 64'sd1))
		else $error("zero exponent result wrong");

	// Negative exponent with base 1 comes back as 1 straight away
	a_neg_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && power_exponent[63] && base_value == 64'sd1
		|=> out_valid && power_result == 64'sd1)
		else $error("negative exponent on base one wrong");

endmodule

bind integer_power_wrapping_top ipw_check u_ipw_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.base_value     (base_value),
	.power_exponent (power_exponent),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.power_result   (power_result)
);
